FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angle tracker RTL
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever cond holds, prop holds too.
`define MAT_ASSERT_IMPLY(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication: whenever cond holds, prop holds in the next cycle.
`define MAT_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/mat_pkg.sv
// ----------------------------------------------------------------------------
// mat_pkg
// Types and constants of the multichannel angle tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mat_pkg;

    localparam int RAW_W    = 12;
    localparam int IN_RAW_W = 16;
    localparam int CHAN_W   = 4;
    localparam int ANGLE_W  = 28;
    localparam int ACC_W    = 48;
    localparam int TURN_W   = 32;
    localparam int FAIL_W   = 8;
    localparam int ALPHA_W  = 17;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // op codes
    localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
    localparam logic [OP_W-1:0] OP_MUX_FAIL  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET_ACC = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_UPDATED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SEEDED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READ_FAILED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_CHANNEL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RESET_DONE  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT = 1'd1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET      = 17'd13107;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE        = 17'd65536;
    localparam logic [FAIL_W-1:0]  FAIL_LIMIT_RESET = 8'd20;
    localparam logic [FAIL_W-1:0]  FAIL_MAX         = 8'd255;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [CHAN_W-1:0]   channel;
        logic [IN_RAW_W-1:0] raw_count;
    } item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]       smoothed;
        logic [RAW_W-1:0]         prev_raw;
        logic signed [ACC_W-1:0]  multi_turn;
        logic signed [TURN_W-1:0] turns;
        logic                     seeded;
        logic [FAIL_W-1:0]        failures;
        logic                     error_flag;
    } chan_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [CHAN_W-1:0]        channel_out;
        logic [ANGLE_W-1:0]       filtered_angle;
        logic signed [ACC_W-1:0]  accumulated_angle;
        logic signed [TURN_W-1:0] turn_count;
        logic                     fault_out;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/mat_if.sv
// ----------------------------------------------------------------------------
// mat_if
// Valid/ready channel interfaces: sample items, results, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mat_item_if;
    logic                           valid;
    logic                           ready;
    logic [mat_pkg::OP_W-1:0]       op;
    logic [mat_pkg::CHAN_W-1:0]     channel;
    logic [mat_pkg::IN_RAW_W-1:0]   raw_count;

    modport source (output valid, op, channel, raw_count, input ready);
    modport sink   (input valid, op, channel, raw_count, output ready);
endinterface

interface mat_result_if;
    logic                                valid;
    logic                                ready;
    logic [mat_pkg::STATUS_W-1:0]        status;
    logic [mat_pkg::CHAN_W-1:0]          channel_out;
    logic [mat_pkg::ANGLE_W-1:0]         filtered_angle;
    logic signed [mat_pkg::ACC_W-1:0]    accumulated_angle;
    logic signed [mat_pkg::TURN_W-1:0]   turn_count;
    logic                                fault_out;

    modport source (output valid, status, channel_out, filtered_angle, accumulated_angle,
                    turn_count, fault_out, input ready);
    modport sink   (input valid, status, channel_out, filtered_angle, accumulated_angle,
                    turn_count, fault_out, output ready);
endinterface

interface mat_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mat_pkg::CFG_IDX_W-1:0]     index;
    logic [mat_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/mat_chan_regs.sv
// ----------------------------------------------------------------------------
// mat_chan_regs
// Per-channel tracker state in flip-flops, one read and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mat_chan_regs #(
    parameter int CHANNELS = 8,
    parameter int IDX_W    = 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [IDX_W-1:0]     idx,
    input  wire logic                 we,
    input  wire mat_pkg::chan_state_t wr_data,
    output mat_pkg::chan_state_t      rd_data
);

    mat_pkg::chan_state_t state_reg [CHANNELS];

    assign rd_data = state_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (we)
        begin
            state_reg[idx] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mat_datapath.sv
// ----------------------------------------------------------------------------
// mat_datapath
// Single-pass update of one channel: seed, unwrap, smoothing, failure count, accumulator reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mat_datapath #(
    parameter int CHANNELS = 8
) (
    input  wire mat_pkg::item_t                    item,
    input  wire mat_pkg::chan_state_t              cur,
    input  wire logic [mat_pkg::ALPHA_W-1:0]       alpha,
    input  wire logic [mat_pkg::FAIL_W-1:0]        fail_limit,
    output logic                                   we,
    output mat_pkg::chan_state_t                   nxt,
    output mat_pkg::result_t                       res
);

    localparam logic [mat_pkg::CHAN_W:0] CH_LIMIT = (mat_pkg::CHAN_W + 1)'(CHANNELS);

    logic                      in_range;
    logic                      raw_ok;
    logic [mat_pkg::RAW_W-1:0] raw;

    logic signed [13:0] d0;
    logic signed [13:0] d;
    logic               wrap_dn;
    logic               wrap_up;
    logic signed [32:0] t_sum;
    logic signed [31:0] t_sat;
    logic signed [48:0] m_sum;
    logic signed [47:0] m_sat;

    logic signed [29:0] e0;
    logic signed [29:0] e;
    logic [16:0]        a;
    logic signed [47:0] prod;
    logic signed [47:0] p;
    logic signed [29:0] step;
    logic [29:0]        s;

    logic [mat_pkg::FAIL_W-1:0] fail_inc;
    logic [mat_pkg::STATUS_W-1:0] status;

    // unwrap the raw step and saturate the turn and multi-turn counters
    always_comb
    begin
        in_range = {1'b0, item.channel} < CH_LIMIT;
        raw_ok   = item.raw_count[15:12] == 4'd0;
        raw      = item.raw_count[11:0];

        d0      = $signed({2'b00, raw}) - $signed({2'b00, cur.prev_raw});
        wrap_dn = d0 > 14'sd2048;
        wrap_up = d0 < -14'sd2048;
        if (wrap_dn)
        begin
            d = d0 - 14'sd4096;
        end
        else if (wrap_up)
        begin
            d = d0 + 14'sd4096;
        end
        else
        begin
            d = d0;
        end

        t_sum = {cur.turns[31], cur.turns};
        if (wrap_dn)
        begin
            t_sum = t_sum - 33'sd1;
        end
        else if (wrap_up)
        begin
            t_sum = t_sum + 33'sd1;
        end
        if (t_sum[32] != t_sum[31])
        begin
            t_sat = t_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        else
        begin
            t_sat = t_sum[31:0];
        end

        m_sum = {cur.multi_turn[47], cur.multi_turn} + 49'({{19{d[13]}}, d, 16'h0000});
        if (m_sum[48] != m_sum[47])
        begin
            m_sat = m_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            m_sat = m_sum[47:0];
        end
    end

    // wrapped error, gain multiply with round half up, wrap into one turn
    always_comb
    begin
        e0 = $signed({2'b00, raw, 16'h0000}) - $signed({2'b00, cur.smoothed});
        if (e0 > 30'sd134217728)
        begin
            e = e0 - 30'sd268435456;
        end
        else if (e0 < -30'sd134217728)
        begin
            e = e0 + 30'sd268435456;
        end
        else
        begin
            e = e0;
        end
        a    = (alpha > mat_pkg::ALPHA_ONE) ? mat_pkg::ALPHA_ONE : alpha;
        prod = e * $signed({1'b0, a});
        p    = prod + 48'sd32768;
        step = p[45:16];
        s    = {2'b00, cur.smoothed} + step;
    end

    always_comb
    begin
        fail_inc = (cur.failures == mat_pkg::FAIL_MAX) ? mat_pkg::FAIL_MAX
                                                       : cur.failures + 8'd1;
        nxt    = cur;
        status = mat_pkg::ST_BAD_CHANNEL;
        case (item.op)
            mat_pkg::OP_SAMPLE, mat_pkg::OP_MUX_FAIL:
            begin
                if (item.op == mat_pkg::OP_SAMPLE && raw_ok)
                begin
                    nxt.failures   = '0;
                    nxt.error_flag = 1'b0;
                    nxt.prev_raw   = raw;
                    nxt.seeded     = 1'b1;
                    if (!cur.seeded)
                    begin
                        nxt.smoothed   = {raw, 16'h0000};
                        nxt.multi_turn = 48'({raw, 16'h0000});
                        nxt.turns      = '0;
                        status         = mat_pkg::ST_SEEDED;
                    end
                    else
                    begin
                        nxt.smoothed   = s[27:0];
                        nxt.multi_turn = m_sat;
                        nxt.turns      = t_sat;
                        status         = mat_pkg::ST_UPDATED;
                    end
                end
                else
                begin
                    nxt.failures   = fail_inc;
                    nxt.error_flag = cur.error_flag | (fail_inc > fail_limit);
                    status         = mat_pkg::ST_READ_FAILED;
                end
            end
            mat_pkg::OP_RESET_ACC:
            begin
                nxt.multi_turn = 48'(cur.smoothed);
                nxt.turns      = '0;
                status         = mat_pkg::ST_RESET_DONE;
            end
            default:
            begin
                status = mat_pkg::ST_BAD_CHANNEL;
            end
        endcase

        we              = in_range;
        res.channel_out = item.channel;
        if (in_range)
        begin
            res.status            = status;
            res.filtered_angle    = nxt.smoothed;
            res.accumulated_angle = nxt.multi_turn;
            res.turn_count        = nxt.turns;
            res.fault_out         = nxt.error_flag;
        end
        else
        begin
            res.status            = mat_pkg::ST_BAD_CHANNEL;
            res.filtered_angle    = '0;
            res.accumulated_angle = '0;
            res.turn_count        = '0;
            res.fault_out         = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/multichannel_angle_tracker_unit.sv
// ----------------------------------------------------------------------------
// multichannel_angle_tracker_unit
// Tracks up to CHANNELS absolute angle sensors (4096 counts per turn).
// Channels:
//   item   - sink: op, channel, raw_count. One beat per sensor event.
//   result - source: status, channel_out, filtered_angle, accumulated_angle,
//            turn_count, fault_out. Exactly one beat per item, in order.
//   cfg    - sink: register writes (index 0 alpha_q16, 1 fail_limit); always
//            ready, write only while no item is in flight.
// Path: an item passes the input register, then the result register.
// Throughput: one item per cycle while no result stalls on result.ready.
// The whole channel update (unwrap, one 30x18 gain multiply, saturation)
// runs in one pass between the two registers, and the per-channel state is
// written back in that same cycle, so a following item on the same channel
// sees the updated state.
// Stall: while a result waits, one more item is taken into the input
// register; after that item.ready drops until result.ready is seen.
// Reset: all channel state, both valid flags and the config registers
// return to their defaults at once; no sweep is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multichannel_angle_tracker_unit #(
    parameter int CHANNELS = 8
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mat_item_if.sink      item,
    mat_result_if.source  result,
    mat_cfg_if.sink       cfg
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [mat_pkg::CHAN_W:0] CH_LIMIT = (mat_pkg::CHAN_W + 1)'(CHANNELS);

    // configuration registers
    logic [mat_pkg::ALPHA_W-1:0] alpha_reg;
    logic [mat_pkg::FAIL_W-1:0]  fail_limit_reg;

    // input stage
    mat_pkg::item_t item_reg;
    logic           item_valid_reg;
    logic           item_valid_next;
    logic           item_take;

    // result stage
    mat_pkg::result_t res_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             adv;
    logic             fire;

    // datapath hookup
    mat_pkg::chan_state_t cur_state;
    mat_pkg::chan_state_t nxt_state;
    mat_pkg::result_t     dp_res;
    logic                 dp_we;

    assign cfg.ready = 1'b1;

    // decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg      <= mat_pkg::ALPHA_RESET;
            fail_limit_reg <= mat_pkg::FAIL_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mat_pkg::REG_ALPHA:      alpha_reg      <= cfg.data;
                mat_pkg::REG_FAIL_LIMIT: fail_limit_reg <= cfg.data[mat_pkg::FAIL_W-1:0];
                default:                 alpha_reg      <= alpha_reg;
            endcase
        end
    end

    // advance the input stage when the result register is empty or drains
    always_comb
    begin
        adv             = !res_valid_reg || result.ready;
        fire            = item_valid_reg && adv;
        item.ready      = !item_valid_reg || adv;
        item_take       = item.valid && item.ready;
        item_valid_next = item_take || (item_valid_reg && !adv);
        res_valid_next  = fire || (res_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.op        <= item.op;
            item_reg.channel   <= item.channel;
            item_reg.raw_count <= item.raw_count;
        end
        if (fire)
        begin
            res_reg <= dp_res;
        end
    end

    mat_chan_regs #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_chan_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (item_reg.channel[IDX_W-1:0]),
        .we      (fire && dp_we),
        .wr_data (nxt_state),
        .rd_data (cur_state)
    );

    mat_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .item       (item_reg),
        .cur        (cur_state),
        .alpha      (alpha_reg),
        .fail_limit (fail_limit_reg),
        .we         (dp_we),
        .nxt        (nxt_state),
        .res        (dp_res)
    );

    assign result.valid             = res_valid_reg;
    assign result.status            = res_reg.status;
    assign result.channel_out       = res_reg.channel_out;
    assign result.filtered_angle    = res_reg.filtered_angle;
    assign result.accumulated_angle = res_reg.accumulated_angle;
    assign result.turn_count        = res_reg.turn_count;
    assign result.fault_out         = res_reg.fault_out;

    `MAT_ASSERT_IMPLY(a_full_blocks_input,
        item_valid_reg && res_valid_reg && !result.ready, !item.ready,
        "input taken while both stages are full and the result stalls")

    `MAT_ASSERT_NEXT(a_fire_fills_result, fire, res_valid_reg,
        "advanced item produced no result beat")

    `MAT_ASSERT_IMPLY(a_bad_channel_zero,
        result.valid && ({1'b0, result.channel_out} >= CH_LIMIT),
        result.status == mat_pkg::ST_BAD_CHANNEL && result.turn_count == 0 &&
        result.accumulated_angle == 0 && result.filtered_angle == 0 && !result.fault_out,
        "out-of-range channel must report bad channel with zero fields")

    `MAT_ASSERT_IMPLY(a_seed_consistent,
        result.valid && result.status == mat_pkg::ST_SEEDED,
        result.turn_count == 0 && !result.fault_out &&
        result.accumulated_angle == 48'(result.filtered_angle),
        "seeded channel must start at zero turns with matching angles")

endmodule

`default_nettype wire
